>>> sv/stbs_pkg.sv
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_W           = 32;
  localparam int IDX_W           = 8;
  localparam int CNT_W           = 9;

  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 9'd256;

  typedef enum logic [0:0] {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] position;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic write;
    logic step;
    logic emit;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic init_empty;
    logic hit;
    logic next_empty;
  } dp_sts_t;

endpackage

>>> sv/stbs_ram.sv
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/stbs_ctrl.sv
module stbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  stbs_pkg::cmd_t    cmd,
  input  stbs_pkg::dp_sts_t sts,
  output stbs_pkg::dp_ctl_t ctl,
  output logic              busy
);

  stbs_pkg::state_t state_r;
  stbs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd == stbs_pkg::CMD_WRITE) begin
            ctl.write = 1'b1;
          end else begin
            ctl.load = 1'b1;
            // empty range: answer at once
            if (sts.init_empty) begin
              ctl.emit = 1'b1;
            end else begin
              state_nxt = stbs_pkg::ST_SEARCH;
            end
          end
        end
      end
      stbs_pkg::ST_SEARCH: begin
        ctl.step = 1'b1;
        if (sts.hit || sts.next_empty) begin
          ctl.emit  = 1'b1;
          state_nxt = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != stbs_pkg::ST_IDLE);

endmodule

>>> sv/stbs_dp.sv
module stbs_dp #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stbs_pkg::in_item_t            in_item,
  input  logic                          cfg_we,
  input  logic [stbs_pkg::CNT_W-1:0]    cfg_wdata,
  input  stbs_pkg::dp_ctl_t             ctl,
  output stbs_pkg::dp_sts_t             sts,
  output logic                          out_valid,
  output stbs_pkg::out_item_t           out_item
);

  localparam int CW = stbs_pkg::CNT_W;
  localparam int KW = stbs_pkg::KEY_W;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CW-1:0]        entry_count_r;
  logic [CW-1:0]        eff_count;
  logic [CW-1:0]        eff_m1;
  logic [CW-1:0]        init_mid;
  logic [CW-1:0]        lo_r;
  logic [CW-1:0]        hi_r;   // exclusive upper bound
  logic [CW-1:0]        mid_r;
  logic signed [KW-1:0] key_r;
  logic [CW-1:0]        lo_nxt;
  logic [CW-1:0]        hi_nxt;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        next_mid;
  logic [KW-1:0]        rdata;
  logic                 less;
  logic                 hit;
  logic                 ram_we;
  logic [AW-1:0]        raddr;
  logic                 out_valid_r;
  stbs_pkg::out_item_t  out_item_r;
  stbs_pkg::out_item_t  result_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= stbs_pkg::ENTRY_COUNT_RST;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  // clamp count to the table depth
  assign eff_count = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                               : entry_count_r;
  assign eff_m1    = eff_count - CW'(1);
  assign init_mid  = eff_m1 >> 1;

  assign ram_we = ctl.write && (32'(in_item.entry_index) < 32'(TABLE_DEPTH));

  // probe compare on the entry read for mid_r
  assign hit  = (rdata == $unsigned(key_r));
  assign less = ($signed(rdata) < key_r);

  assign lo_nxt   = less ? (mid_r + CW'(1)) : lo_r;
  assign hi_nxt   = less ? hi_r : mid_r;
  assign mid_sum  = {1'b0, lo_nxt} + {1'b0, hi_nxt} - (CW+1)'(1);
  assign next_mid = mid_sum[CW:1];

  // issue the next probe in the same cycle as the compare
  assign raddr = ctl.load ? AW'(init_mid) : AW'(next_mid);

  stbs_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_item.entry_index)),
    .wdata ($unsigned(in_item.key_value)),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lo_r  <= '0;
      hi_r  <= eff_count;
      mid_r <= init_mid;
      key_r <= in_item.key_value;
    end else if (ctl.step) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= next_mid;
    end
  end

  assign sts.init_empty = (eff_count == '0);
  assign sts.hit        = hit;
  assign sts.next_empty = (lo_nxt >= hi_nxt);

  always_comb begin
    result_nxt.found    = ctl.step & hit;
    result_nxt.position = result_nxt.found ? (mid_r + CW'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_item_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> sv/sorted_table_binary_search.sv
// Binary search over a table of signed 32-bit entries kept in ascending order.
// A write item (cmd = write) stores one entry and gives no result; busy stays
// low. A search item over a non-empty range raises busy and probes one table
// entry per cycle, so a search over n entries takes up to floor(log2(n)) + 1
// probes (9 for 256 entries) and its result appears in the cycle after the
// last probe. The per-cycle probe is set by the table RAM's registered read
// feeding the key compare, which selects the next probe address in the same
// cycle. An empty range answers with out_valid in the next cycle. out_valid
// is high for exactly one cycle and cannot be held off; take out_item in that
// cycle. A new item may start in the cycle the result shows. Table contents
// are undefined after reset until written; entry_count resets to 256 and is
// clamped to the table depth.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  stbs_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output stbs_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic [stbs_pkg::CNT_W-1:0] cfg_wdata
);

  stbs_pkg::dp_ctl_t ctl;
  stbs_pkg::dp_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_item.cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |-> (out_item.position == '0))
    else $error("miss reported with nonzero position");

  a_hit_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found) |-> (out_item.position != '0))
    else $error("hit reported with zero position");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.cmd == stbs_pkg::CMD_WRITE)) |=> !out_valid)
    else $error("write item produced a result");

  a_busy_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy && (in_item.cmd == stbs_pkg::CMD_SEARCH)))
    else $error("busy rose without an accepted search item");

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = stbs_pkg::TABLE_DEPTH_DEF;
  localparam int KW         = stbs_pkg::KEY_W;
  localparam int IW         = stbs_pkg::IDX_W;
  localparam int CW         = stbs_pkg::CNT_W;
  localparam int ITEM_GOAL  = 1700;
  localparam int SETTLE     = 12;
  localparam int CYCLE_CAP  = 600000;

  // Mirrors the table and entry count, predicts each search result and
  // compares it against what the block returns.
  class lookup_board;
    logic signed [KW-1:0]  tbl [DEPTH];
    bit                    written [DEPTH];
    logic [CW-1:0]         entry_count;
    stbs_pkg::out_item_t   expected_hits [$];
    int                    errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        tbl[i] = '0;
        written[i] = 1'b0;
      end
      entry_count = stbs_pkg::ENTRY_COUNT_RST;
      errors = 0;
    endfunction

    function void set_entry_count(logic [CW-1:0] value);
      entry_count = value;
    endfunction

    // Walk the search for key. Returns the first probe index that was never
    // written, or -1 when the whole walk stays on written entries.
    function int walk_search(logic signed [KW-1:0] key, output stbs_pkg::out_item_t res);
      int lo;
      int hi;
      int mid;
      int span;
      span = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
      lo = 0;
      hi = span - 1;
      res.found = 1'b0;
      res.position = '0;
      while (hi >= lo) begin
        mid = (lo + hi) / 2;
        if (!written[mid]) return mid;
        if (tbl[mid] == key) begin
          res.found = 1'b1;
          res.position = CW'(mid + 1);
          return -1;
        end
        if (tbl[mid] < key) lo = mid + 1;
        else hi = mid - 1;
      end
      return -1;
    endfunction

    function void note_item(stbs_pkg::in_item_t it);
      stbs_pkg::out_item_t res;
      if (it.cmd == stbs_pkg::CMD_WRITE) begin
        tbl[it.entry_index] = it.key_value;
        written[it.entry_index] = 1'b1;
      end else begin
        void'(walk_search(it.key_value, res));
        expected_hits.push_back(res);
      end
    endfunction

    function void check_result(stbs_pkg::out_item_t got);
      stbs_pkg::out_item_t want;
      if (expected_hits.size() == 0) begin
        $error("unexpected result: found=%0d position=%0d", got.found, got.position);
        errors++;
        return;
      end
      want = expected_hits.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, got.position);
        errors++;
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  stbs_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  stbs_pkg::out_item_t out_item;
  logic                cfg_we = 1'b0;
  logic [CW-1:0]       cfg_wdata = '0;

  lookup_board sb;
  int          burst_left = 0;
  int          items_sent = 0;

  sorted_table_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Present one item; hold start through busy until the block takes it.
  task automatic issue(stbs_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic write_entry(logic [IW-1:0] idx, logic signed [KW-1:0] value);
    stbs_pkg::in_item_t it;
    it.cmd = stbs_pkg::CMD_WRITE;
    it.entry_index = idx;
    it.key_value = value;
    issue(it);
  endtask

  // Search for key; if the walk would touch an unwritten entry, fill it instead.
  task automatic lookup(logic signed [KW-1:0] key);
    stbs_pkg::in_item_t  it;
    stbs_pkg::out_item_t dummy;
    int hole;
    hole = sb.walk_search(key, dummy);
    if (hole >= 0) begin
      write_entry(IW'(hole), $urandom);
    end else begin
      it.cmd = stbs_pkg::CMD_SEARCH;
      it.entry_index = IW'($urandom);
      it.key_value = key;
      issue(it);
    end
  endtask

  // Drain every outstanding result, settle, then write the entry count.
  task automatic set_count(logic [CW-1:0] value);
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_entry_count(value);
    burst_left = 0;
  endtask

  task automatic run_phase();
    logic [CW-1:0]        cnt;
    int                   span;
    int                   pick;
    int                   searches;
    int                   vals [$];
    int                   base;
    logic signed [KW-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 45) cnt = CW'($urandom_range(1, 8));
    else if (pick < 80) cnt = CW'($urandom_range(9, 40));
    else if (pick < 88) cnt = CW'($urandom_range(41, 255));
    else if (pick < 93) cnt = CW'(DEPTH);
    else if (pick < 96) cnt = CW'($urandom_range(DEPTH + 1, 511));
    else cnt = '0;
    set_count(cnt);
    span = (cnt > DEPTH) ? DEPTH : int'(cnt);

    // Build a sorted set: wide random, narrow with duplicates, or pinned extremes.
    pick = $urandom_range(0, 2);
    base = $urandom;
    for (int i = 0; i < span; i++) begin
      if (pick == 1) begin
        base = base + $urandom_range(0, 3);
        vals.push_back(base);
      end else begin
        vals.push_back($urandom);
      end
    end
    vals.sort();
    if (pick == 2 && span > 0) begin
      vals[0] = 32'h8000_0000;
      vals[span-1] = 32'h7fff_ffff;
    end
    if ($urandom_range(0, 1) == 0) begin
      for (int i = 0; i < span; i++) write_entry(IW'(i), vals[i]);
    end else begin
      for (int i = span - 1; i >= 0; i--) write_entry(IW'(i), vals[i]);
    end

    searches = $urandom_range(10, 40);
    for (int s = 0; s < searches; s++) begin
      pick = $urandom_range(0, 99);
      if (span > 0) key = sb.tbl[$urandom_range(0, span - 1)];
      else key = $urandom;
      if (pick < 60) begin
        lookup(key);
      end else if (pick < 75) begin
        lookup(($urandom_range(0, 1) == 0) ? key + 1 : key - 1);
      end else if (pick < 85) begin
        lookup($urandom);
      end else if (pick < 90) begin
        lookup(($urandom_range(0, 1) == 0) ? 32'sh8000_0000 : 32'sh7fff_ffff);
      end else begin
        // Noise: overwrite an entry, possibly breaking the order.
        write_entry(IW'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset count of 256: the first probe lands on entry 127.
    write_entry(8'd127, 32'sd0);
    lookup(32'sd0);

    set_count('0);
    lookup(32'sh8000_0000);
    lookup(32'sh7fff_ffff);

    set_count(9'd1);
    write_entry(8'd0, 32'sh8000_0000);
    lookup(32'sh8000_0000);
    lookup(32'sh7fff_ffff);
    lookup(32'sd0);
    write_entry(8'd255, 32'sh7fff_ffff);

    set_count(9'd2);
    write_entry(8'd1, 32'sh7fff_ffff);
    lookup(32'sh7fff_ffff);
    lookup(32'sh8000_0000);
    lookup(-32'sd1);

    set_count(9'd3);
    write_entry(8'd2, 32'sh7fff_ffff);
    lookup(32'sh7fff_ffff);
    lookup(32'sh7fff_fffe);

    while (items_sent < ITEM_GOAL) run_phase();

    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() > 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sorted_table_binary_search.f
sv/stbs_pkg.sv
sv/stbs_ram.sv
sv/stbs_ctrl.sv
sv/stbs_dp.sv
sv/sorted_table_binary_search.sv
tb/testbench.sv
